### rtl/core/swa_pkg.sv
`default_nettype none

package swa_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int ADDR_BITS   = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_BITS    = 7;
    localparam int SUM_BITS    = 22;
    localparam int POS_BITS    = 16;
    localparam int AVG_BITS    = 24;
    localparam int FRAC_BITS   = 8;
    localparam int DVD_BITS    = SUM_BITS + FRAC_BITS;
    localparam int REM_BITS    = LEN_BITS + 1;
    localparam int STEP_BITS   = 5;

    localparam logic [LEN_BITS-1:0]  LEN_RESET = LEN_BITS'(3);
    localparam logic [POS_BITS-1:0]  POS_LIMIT = '1;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DVD_BITS - 1);

    // One divide job handed from the front to the back.
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic [LEN_BITS-1:0]        len;
        logic [POS_BITS-1:0]        pos;
    } t_job;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } t_back_state;

    // Clamp the programmed window length into 1..WINDOW_MAX.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS-1:0] res;
        if (len == '0) begin
            res = LEN_BITS'(1);
        end else if (len > LEN_BITS'(WINDOW_MAX)) begin
            res = LEN_BITS'(WINDOW_MAX);
        end else begin
            res = len;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sliding_window_average_unit.sv
// Simple moving average over a programmable window of signed 16-bit samples.
//
// Input stream: s_axis_tdata carries the sample, s_axis_tlast marks the last
// sample of a sequence. The first window_len-1 samples of a sequence give no
// output; every later sample gives one output transfer on m_axis with the
// window average in signed Q.8 (truncated toward zero) and the 1-based index
// of the newest sample, saturating at 65535. After a tlast transfer the fill
// count, running sum, ring position and index clear.
// Configuration: a transfer on i_cfg_valid/o_cfg_ready writes window_len
// (0 acts as 1, above 64 acts as 64) and starts a new sequence. Write it only
// while the block is idle; o_cfg_ready is always high.
// Timing: the front handles each sample as a ring read, then an update, and
// holds the update while it has a job and the job queue is full; the back
// runs a restoring divider at one quotient bit per cycle, which sets the
// sustained sample rate. The front can take new samples while the back divides.
// A two-entry job queue and the output register decouple the sides, so a
// stalled receiver only holds off input once both are full.
// Reset clears all control state and sets window_len to 3; no ring clearing
// pass is needed.
`default_nettype none

module sliding_window_average_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [swa_pkg::LEN_BITS-1:0]     i_cfg_data,     // window_len
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire [15:0]                      s_axis_tdata,   // [15:0] sample
    input  wire                             s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [39:0]                     m_axis_tdata    // [23:0] average_q8,
                                                            // [39:24] window_end
);

    swa_pkg::t_job job_in;
    swa_pkg::t_job job_out;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;

    assign o_cfg_ready = 1'b1;

    // Front: accept samples, maintain ring and running sum, issue divide jobs.
    swa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job_in)
    );

    // Hold pending jobs so the front keeps going while the divider works.
    swa_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (job_in),
        .i_pop  (pop),
        .o_data (job_out),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    // Back: divide sum * 256 by the window length and drive the output register.
    swa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_average_q8(m_axis_tdata[23:0]),
        .o_window_end(m_axis_tdata[39:24])
    );

endmodule

`default_nettype wire

### rtl/core/swa_queue.sv
`default_nettype none

module swa_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  swa_pkg::t_job    i_data,
    input  wire              i_pop,
    output swa_pkg::t_job    o_data,
    output logic             o_empty,
    output logic             o_full
);

    swa_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

`default_nettype wire

### rtl/core/swa_front.sv
`default_nettype none

module swa_front (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    input  wire [swa_pkg::LEN_BITS-1:0]           i_cfg_data,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire signed [swa_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire                                   i_last,
    input  wire                                   i_q_full,
    output logic                                  o_push,
    output swa_pkg::t_job                         o_job
);

    localparam int AB = swa_pkg::ADDR_BITS;
    localparam int LB = swa_pkg::LEN_BITS;
    localparam int SB = swa_pkg::SUM_BITS;
    localparam int PB = swa_pkg::POS_BITS;

    logic signed [swa_pkg::SAMPLE_BITS-1:0] r_ring [swa_pkg::WINDOW_MAX];
    logic signed [swa_pkg::SAMPLE_BITS-1:0] r_old;
    logic signed [swa_pkg::SAMPLE_BITS-1:0] r_sample;
    logic                                   r_last;

    swa_pkg::t_front_state r_state, n_state;
    logic [LB-1:0]        r_len_cfg;
    logic [AB-1:0]        r_wp, n_wp;
    logic [LB-1:0]        r_fill, n_fill;
    logic signed [SB-1:0] r_sum, n_sum;
    logic [PB-1:0]        r_pos, n_pos;

    logic [LB-1:0] len;
    logic          accept;
    logic          was_full;
    logic          produce;
    logic          stall;
    logic          commit;

    assign len    = swa_pkg::eff_len(r_len_cfg);
    assign accept = i_valid && o_ready;

    // Update arithmetic for the held sample.
    always_comb begin
        was_full = (r_fill >= len);
        n_sum    = r_sum + SB'(r_sample)
                   - (was_full ? SB'(r_old) : SB'(0));
        n_fill   = was_full ? r_fill : r_fill + LB'(1);
        n_pos    = (r_pos == swa_pkg::POS_LIMIT) ? r_pos : r_pos + PB'(1);
        n_wp     = ((LB'(r_wp) + LB'(1)) >= len) ? AB'(0) : r_wp + AB'(1);
        produce  = (n_fill >= len);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swa_pkg::F_IDLE: begin
                if (accept) begin
                    n_state = swa_pkg::F_UPDATE;
                end
            end
            swa_pkg::F_UPDATE: begin
                if (!stall) begin
                    n_state = swa_pkg::F_IDLE;
                end
            end
            default: n_state = swa_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        stall   = 1'b0;
        commit  = 1'b0;
        case (r_state)
            swa_pkg::F_IDLE: begin
                o_ready = 1'b1;
            end
            swa_pkg::F_UPDATE: begin
                stall  = produce && i_q_full;
                commit = !stall;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        o_push = commit && produce;
    end

    assign o_job.sum = n_sum;
    assign o_job.len = len;
    assign o_job.pos = n_pos;

    // Ring store: read the outgoing entry on accept, write the new one on commit.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old    <= r_ring[r_wp];
            r_sample <= i_sample;
            r_last   <= i_last;
        end
        if (commit) begin
            r_ring[r_wp] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= swa_pkg::F_IDLE;
            r_len_cfg <= swa_pkg::LEN_RESET;
            r_wp      <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_pos     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_len_cfg <= i_cfg_data;
                r_wp      <= '0;
                r_fill    <= '0;
                r_sum     <= '0;
                r_pos     <= '0;
            end else if (commit) begin
                if (r_last) begin
                    r_wp   <= '0;
                    r_fill <= '0;
                    r_sum  <= '0;
                    r_pos  <= '0;
                end else begin
                    r_wp   <= n_wp;
                    r_fill <= n_fill;
                    r_sum  <= n_sum;
                    r_pos  <= n_pos;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/swa_back.sv
`default_nettype none

module swa_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_q_empty,
    input  swa_pkg::t_job                       i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [swa_pkg::AVG_BITS-1:0]        o_average_q8,
    output logic [swa_pkg::POS_BITS-1:0]        o_window_end
);

    localparam int DB = swa_pkg::DVD_BITS;
    localparam int RB = swa_pkg::REM_BITS;
    localparam int SB = swa_pkg::SUM_BITS;

    swa_pkg::t_back_state r_state, n_state;

    logic [DB-1:0]                 r_quo;
    logic [RB-1:0]                 r_rem;
    logic [swa_pkg::LEN_BITS-1:0]  r_len;
    logic [swa_pkg::POS_BITS-1:0]  r_pos;
    logic                          r_neg;
    logic [swa_pkg::STEP_BITS-1:0] r_step;
    logic                          r_out_valid;

    logic [SB-1:0] mag;
    logic [RB-1:0] trial;
    logic          fits;
    logic [DB-1:0] signed_quo;
    logic          out_free;
    logic          load_out;

    assign mag   = i_job.sum[SB-1] ? SB'(-i_job.sum) : SB'(i_job.sum);
    assign trial = {r_rem[RB-2:0], r_quo[DB-1]};
    assign fits  = (trial >= RB'(r_len));
    assign signed_quo = r_neg ? DB'(-r_quo) : r_quo;
    assign out_free   = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            swa_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = swa_pkg::B_DIV;
                end
            end
            swa_pkg::B_DIV: begin
                if (r_step == swa_pkg::LAST_STEP) begin
                    n_state = swa_pkg::B_DONE;
                end
            end
            swa_pkg::B_DONE: begin
                if (out_free) begin
                    n_state = swa_pkg::B_IDLE;
                end
            end
            default: n_state = swa_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            swa_pkg::B_IDLE: o_pop    = !i_q_empty;
            swa_pkg::B_DONE: load_out = out_free;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Restoring divide, one quotient bit a cycle, on the magnitude of sum * 256.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo  <= {mag, swa_pkg::FRAC_BITS'(0)};
            r_rem  <= '0;
            r_len  <= i_job.len;
            r_pos  <= i_job.pos;
            r_neg  <= i_job.sum[SB-1];
        end else if (r_state == swa_pkg::B_DIV) begin
            r_rem <= fits ? trial - RB'(r_len) : trial;
            r_quo <= {r_quo[DB-2:0], fits};
        end
        if (load_out) begin
            o_average_q8 <= signed_quo[swa_pkg::AVG_BITS-1:0];
            o_window_end <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swa_pkg::B_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
            end else if (r_state == swa_pkg::B_DIV) begin
                r_step <= r_step + swa_pkg::STEP_BITS'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire
